>>> rtl/multi_button_debounce_scanner_macros.svh
// assertion helpers, clocked on clk and held off during reset
`ifndef MULTI_BUTTON_DEBOUNCE_SCANNER_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCE_SCANNER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define DBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/dbs_pkg.sv
package dbs_pkg;

  localparam int NUM_BUTTONS = 6;
  localparam int TIME_BITS   = 32;
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  // fixed field widths
  localparam int NOW_W   = 32;
  localparam int LEVEL_W = 6;
  localparam int DBT_W   = 16;
  localparam int BIDX_W  = 3;
  localparam int CFG_W   = 16;
  localparam int CMP_W   = (TIME_BITS > DBT_W) ? TIME_BITS : DBT_W;

  // register indexes
  localparam logic REG_DEBOUNCE    = 1'b0;
  localparam logic REG_ACTIVE_MASK = 1'b1;

  localparam logic [DBT_W-1:0]   RESET_DEBOUNCE = DBT_W'(50);
  localparam logic [LEVEL_W-1:0] RESET_MASK     = '0;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  typedef struct packed {
    logic                 last_raw;
    logic                 stable;
    logic [TIME_BITS-1:0] chg_time;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    entry_t wr;
    logic   stop;
    logic   press;
  } eval_res_t;

  // bit i of a 6-bit field, 0 for buttons beyond the field
  function automatic logic bit_at(logic [LEVEL_W-1:0] v, logic [IDX_W-1:0] i);
    logic b;
    b = 1'b0;
    for (int k = 0; k < LEVEL_W; k++) begin
      if (k == int'(i)) b = v[k];
    end
    return b;
  endfunction

  // released level on both level bits, zero change time
  function automatic entry_t reset_entry(logic [IDX_W-1:0] i);
    entry_t e;
    e.last_raw = ~bit_at(RESET_MASK, i);
    e.stable   = ~bit_at(RESET_MASK, i);
    e.chg_time = '0;
    return e;
  endfunction

endpackage

>>> rtl/dbs_state_mem.sv
module dbs_state_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  dbs_pkg::mem_req_t req,
  output dbs_pkg::entry_t   rdata
);

  dbs_pkg::entry_t               mem [dbs_pkg::NUM_BUTTONS];
  logic [dbs_pkg::NUM_BUTTONS-1:0] vld_r;
  dbs_pkg::entry_t               rd_q_r;
  dbs_pkg::entry_t               rd_rst_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r   <= mem[req.raddr];
      rd_rst_r <= dbs_pkg::reset_entry(req.raddr);
      rd_vld_r <= vld_r[req.raddr];
    end
  end

  // valid bits: a never-written entry reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  assign rdata = rd_vld_r ? rd_q_r : rd_rst_r;

endmodule

>>> rtl/dbs_eval.sv
module dbs_eval (
  input  dbs_pkg::entry_t                     ent,
  input  logic                                level,
  input  logic                                active,
  input  logic [dbs_pkg::TIME_BITS-1:0]       now,
  input  logic [dbs_pkg::DBT_W-1:0]           dbt,
  output dbs_pkg::eval_res_t                  res
);

  logic                          chg;
  logic [dbs_pkg::TIME_BITS-1:0] ct_new;
  logic [dbs_pkg::TIME_BITS-1:0] diff;
  logic                          held;
  logic                          stab;

  always_comb begin
    chg    = (level != ent.last_raw);
    ct_new = chg ? now : ent.chg_time;
    diff   = now - ct_new;
    held   = dbs_pkg::CMP_W'(diff) >= dbs_pkg::CMP_W'(dbt);
    stab   = (level != ent.stable) && held;

    res.wr.last_raw = level;
    res.wr.stable   = stab ? level : ent.stable;
    res.wr.chg_time = ct_new;
    res.stop        = stab;
    res.press       = stab && (level == active);
  end

endmodule

>>> rtl/multi_button_debounce_scanner.sv
// channel   ports                           moves
// -------   -----------------------------   ------------------------------
// in        in_valid/in_stall               poll item: time and raw levels
// out       out_valid/out_stall             result item: pressed, index
// cfg       cfg_we/cfg_index/cfg_wdata      register write, no read-back
//
// taking an item reads button 0; the scan then visits one button per step,
// stopping at the first that settles, and a final step hands off the result
// the per-button state memory has one read port, so one button per cycle
// reset is synchronous; the state memory needs no clearing pass, its valid
// bits make unwritten entries read as released level and zero time
// a result stalled at the output holds the scan in its last step, while the
// next item is taken as soon as the scan is idle again

`include "multi_button_debounce_scanner_macros.svh"

module multi_button_debounce_scanner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dbs_pkg::NOW_W-1:0]     in_now_ms,
  input  logic [dbs_pkg::LEVEL_W-1:0]   in_raw_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_pressed,
  output logic [dbs_pkg::BIDX_W-1:0]    out_button_index,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [dbs_pkg::CFG_W-1:0]     cfg_wdata
);

  // scan states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [dbs_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [dbs_pkg::TIME_BITS-1:0]   now_r;
  logic [dbs_pkg::LEVEL_W-1:0]     raw_r;
  logic [dbs_pkg::DBT_W-1:0]       dbt_r;
  logic [dbs_pkg::LEVEL_W-1:0]     mask_r;
  logic                            res_press_r, res_press_nxt;
  logic [dbs_pkg::BIDX_W-1:0]      res_idx_r, res_idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_pressed_r;
  logic [dbs_pkg::BIDX_W-1:0]      out_button_index_r;

  logic                  in_acc;
  logic                  finish;
  logic                  out_load;
  dbs_pkg::mem_req_t     mreq;
  dbs_pkg::entry_t       ent;
  dbs_pkg::eval_res_t    ev;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // scan stops at the first button that settles, or after the last one
  assign finish   = (state_r == ST_SCAN) && (ev.stop || (idx_r == dbs_pkg::LAST_IDX));
  // result moves to the output register once that is free
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // read next button while writing back the current one
  always_comb begin
    mreq.we    = (state_r == ST_SCAN);
    mreq.waddr = idx_r;
    mreq.wdata = ev.wr;
    mreq.re    = in_acc || ((state_r == ST_SCAN) && !finish);
    mreq.raddr = in_acc ? '0 : (idx_r + 1'b1);
  end

  dbs_state_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rdata (ent)
  );

  dbs_eval u_eval (
    .ent    (ent),
    .level  (dbs_pkg::bit_at(raw_r, idx_r)),
    .active (dbs_pkg::bit_at(mask_r, idx_r)),
    .now    (now_r),
    .dbt    (dbt_r),
    .res    (ev)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    res_press_nxt = res_press_r;
    res_idx_nxt   = res_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_nxt     = ST_DONE;
          res_press_nxt = ev.press;
          res_idx_nxt   = ev.press ? dbs_pkg::BIDX_W'(idx_r) : '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      dbt_r       <= dbs_pkg::RESET_DEBOUNCE;
      mask_r      <= dbs_pkg::RESET_MASK;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          dbs_pkg::REG_DEBOUNCE:    dbt_r  <= cfg_wdata[dbs_pkg::DBT_W-1:0];
          dbs_pkg::REG_ACTIVE_MASK: mask_r <= cfg_wdata[dbs_pkg::LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_now_ms[dbs_pkg::TIME_BITS-1:0];
      raw_r <= in_raw_levels;
    end
    res_press_r <= res_press_nxt;
    res_idx_r   <= res_idx_nxt;
    if (out_load) begin
      out_pressed_r      <= res_press_r;
      out_button_index_r <= res_idx_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pressed      = out_pressed_r;
  assign out_button_index = out_button_index_r;

  // the scan never runs past the last button
  `DBS_ASSERT_SAME(a_idx_range, state_r == ST_SCAN, idx_r <= dbs_pkg::LAST_IDX)
  // write-back and look-ahead read never hit the same entry
  `DBS_ASSERT_SAME(a_no_rw_clash, mreq.we && mreq.re, mreq.waddr != mreq.raddr)
  // a taken item starts its scan at button 0
  `DBS_ASSERT_NEXT(a_scan_start, in_acc, (state_r == ST_SCAN) && (idx_r == '0))
  // no press means index 0
  `DBS_ASSERT_SAME(a_idx_zero, out_valid_r && !out_pressed_r, out_button_index_r == '0)

endmodule
